>>> rtl/md5_pkg.sv
package md5_pkg;

   localparam int unsigned NumRounds = 64;
   localparam int unsigned MsgWords  = 12;
   localparam int unsigned NumQwords = 6;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   // padding word after the message and the fixed bit length
   localparam logic [31:0] PadWord   = 32'h00000080;
   localparam logic [31:0] BitLength = 32'd384;

   localparam logic [31:0] RoundConst [NumRounds] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] RotAmount [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic [1:0] {
      PHASE_F = 2'd0,
      PHASE_G = 2'd1,
      PHASE_H = 2'd2,
      PHASE_I = 2'd3
   } phase_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } state_type;

   typedef logic [MsgWords-1:0][31:0] msg_words_type;

   // message word used by a round
   function automatic logic [3:0] word_index(input logic [5:0] r);
      logic [3:0] g;
      begin
         case (phase_type'(r[5:4]))
            PHASE_F: g = r[3:0];
            PHASE_G: g = 4'(5 * r + 1);
            PHASE_H: g = 4'(3 * r + 5);
            PHASE_I: g = 4'(7 * r);
            default: g = r[3:0];
         endcase
         return g;
      end
   endfunction

   // constant words past the message: padding, length, zeros
   function automatic logic [31:0] pad_word(input logic [3:0] g);
      logic [31:0] w;
      begin
         case (g)
            4'd12:   w = PadWord;
            4'd14:   w = BitLength;
            default: w = '0;
         endcase
         return w;
      end
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      begin
         dbl = {v, v} << s;
         return dbl[63:32];
      end
   endfunction

   // one MD5 step
   function automatic state_type md5_round(input state_type s, input logic [31:0] w,
                                           input logic [5:0] r);
      logic [31:0] f;
      logic [31:0] sum;
      state_type   n;
      begin
         case (phase_type'(r[5:4]))
            PHASE_F: f = (s.b & s.c) | (~s.b & s.d);
            PHASE_G: f = (s.b & s.d) | (s.c & ~s.d);
            PHASE_H: f = s.b ^ s.c ^ s.d;
            PHASE_I: f = s.c ^ (s.b | ~s.d);
            default: f = s.b ^ s.c ^ s.d;
         endcase
         sum = s.a + f + RoundConst[r] + w;
         n.a = s.d;
         n.d = s.c;
         n.c = s.b;
         n.b = s.b + rotl(sum, RotAmount[{r[5:4], r[1:0]}]);
         return n;
      end
   endfunction

endpackage

>>> rtl/md5_48_byte_message_digest.sv
// MD5 digest of a fixed 48-byte message, fully pipelined.
//
// Request channel: req_valid/req_ready with six 64-bit little-endian
// quadwords; the low half of each quadword is the even MD5 word. Padding
// (0x80 word, zero words, bit length 384) is built in, so one request is
// exactly one 512-bit block.
// Response channel: rsp_valid/rsp_ready with the four digest words A..D.
//
// Pipeline: a request accepted on req_* passes through the 64 round stages
// and one final-add stage before its digest shows on rsp_*. Throughput: one
// request per cycle while the response register does not stall; each of the 64
// stages holds one MD5 round, so the round adder chain sets the clock.
// Every request gives exactly one response, in request order.
//
// Stall: the whole pipeline advances together when the response register is
// empty or being taken. While rsp_valid is high and rsp_ready is low, all
// stages hold and req_ready drops; bubbles in the pipe cost nothing until
// the response register fills.
// Reset: synchronous, active high; clears all stage valid bits and the
// response valid. Data registers are not reset.
module md5_48_byte_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_message_qword_0,
   input  logic [63:0] req_message_qword_1,
   input  logic [63:0] req_message_qword_2,
   input  logic [63:0] req_message_qword_3,
   input  logic [63:0] req_message_qword_4,
   input  logic [63:0] req_message_qword_5,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_a,
   output logic [31:0] rsp_digest_b,
   output logic [31:0] rsp_digest_c,
   output logic [31:0] rsp_digest_d
);

   localparam int unsigned Rounds = md5_pkg::NumRounds;

   // per-stage valid bits, bit r set when round r's register holds a request
   logic [Rounds-1:0]          vld_ff;
   logic                       rsp_valid_ff;
   md5_pkg::state_type         st_ff  [0:Rounds-1];
   md5_pkg::state_type         st_in  [0:Rounds-1];
   md5_pkg::state_type         st_src [0:Rounds-1];
   md5_pkg::msg_words_type     msg_ff [0:Rounds-2];
   md5_pkg::msg_words_type     msg_src[0:Rounds-1];
   logic [31:0]                dig_a_ff, dig_b_ff, dig_c_ff, dig_d_ff;
   logic                       advance;

   // move everything when the response slot is free or draining
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digest_a = dig_a_ff;
   assign rsp_digest_b = dig_b_ff;
   assign rsp_digest_c = dig_c_ff;
   assign rsp_digest_d = dig_d_ff;

   // round 0 works straight off the request and the initial chaining values
   assign msg_src[0] = {req_message_qword_5, req_message_qword_4, req_message_qword_3,
                        req_message_qword_2, req_message_qword_1, req_message_qword_0};
   assign st_src[0]  = '{a: md5_pkg::InitA, b: md5_pkg::InitB,
                         c: md5_pkg::InitC, d: md5_pkg::InitD};

   for (genvar r = 1; r < Rounds; r++) begin : g_src
      assign msg_src[r] = msg_ff[r-1];
      assign st_src[r]  = st_ff[r-1];
   end

   for (genvar r = 0; r < Rounds; r++) begin : g_round
      localparam logic [3:0] G = md5_pkg::word_index(6'(r));
      logic [31:0] word;
      // message words come along the pipe; padding words are constants
      if (G < md5_pkg::MsgWords) begin : g_msg
         assign word = msg_src[r][G];
      end else begin : g_pad
         assign word = md5_pkg::pad_word(G);
      end
      assign st_in[r] = md5_pkg::md5_round(st_src[r], word, 6'(r));
   end

   // control: valid bits shift with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[Rounds-2:0], req_valid};
         rsp_valid_ff <= vld_ff[Rounds-1];
      end
   end

   // payload: rounds, message carry and final add back to the initial values
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < Rounds; r++) begin
            st_ff[r] <= st_in[r];
         end
         for (int r = 0; r < Rounds - 1; r++) begin
            msg_ff[r] <= msg_src[r];
         end
         dig_a_ff <= md5_pkg::InitA + st_ff[Rounds-1].a;
         dig_b_ff <= md5_pkg::InitB + st_ff[Rounds-1].b;
         dig_c_ff <= md5_pkg::InitC + st_ff[Rounds-1].c;
         dig_d_ff <= md5_pkg::InitD + st_ff[Rounds-1].d;
      end
   end

   // an accepted request lands in the first round stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   // a request leaving the last round becomes a response
   a_last_to_rsp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[Rounds-1] && advance |=> rsp_valid)
      else $error("request lost between last round and response");

   // a stall freezes the valid bits of every stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule
